[src/uart_line_command_decoder_defines.svh]
`ifndef UART_LINE_COMMAND_DECODER_DEFINES_SVH
`define UART_LINE_COMMAND_DECODER_DEFINES_SVH

// Check a condition in the same cycle.
`define ULCD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the next cycle.
`define ULCD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ulcd_pkg.sv]
`timescale 1ns / 1ps

package ulcd_pkg;

    localparam int LINE_BYTES_DEF = 32;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_VT    = 8'h0B;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_F     = 8'h46;
    localparam logic [7:0] CHR_M     = 8'h4D;
    localparam logic [7:0] CHR_O     = 8'h4F;
    localparam logic [7:0] CHR_P     = 8'h50;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_U     = 8'h55;
    localparam logic [7:0] CHR_W     = 8'h57;

    localparam logic [6:0] VALUE_CAP = 7'd101;
    localparam logic [6:0] LEVEL_MAX = 7'd100;

    typedef enum logic [4:0] {
        PH_START,
        PH_O,
        PH_OF,
        PH_OFF,
        PH_S,
        PH_ST,
        PH_STA,
        PH_STAT,
        PH_STATU,
        PH_STATUS,
        PH_P,
        PH_PW,
        PH_PWM,
        PH_BLANK,
        PH_SIGN,
        PH_DIGITS,
        PH_FAIL
    } phase_t;

    typedef enum logic [2:0] {
        CODE_OFF    = 3'd0,
        CODE_STATUS = 3'd1,
        CODE_LEVEL  = 3'd2,
        CODE_CMD    = 3'd3,
        CODE_RANGE  = 3'd4,
        CODE_LONG   = 3'd5
    } code_t;

    typedef struct packed {
        phase_t     phase;
        logic [6:0] value;
        logic       neg;
        logic       ended;
    } line_state_t;

    typedef struct packed {
        logic       emit;
        logic       restart;
        logic       count;
        code_t      code;
        logic [6:0] level;
    } parse_result_t;

endpackage

[src/uart_line_command_decoder.sv]
// Path: an input transfer is captured in the input register, and the recognizer step
// then writes any result it produces into the output register that drives the output.
// Throughput: one byte per cycle; the input register, recognizer step and result
// register are a single pass with no iteration.
// A result waiting on the output holds the pipeline only when the next byte also
// produces a result. Reset (rst_n low) clears the line state and both valid flags.
`timescale 1ns / 1ps
`include "uart_line_command_decoder_defines.svh"

module uart_line_command_decoder
#(
    parameter int LINE_BYTES = ulcd_pkg::LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] level, [7] zero
    output logic [2:0] m_axis_tuser    // [2:0] response_code
);

    localparam int CW = $clog2(LINE_BYTES);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic [CW-1:0]           held_reg;
    logic [CW-1:0]           held_next;
    ulcd_pkg::line_state_t   state_reg;
    ulcd_pkg::line_state_t   state_next;
    ulcd_pkg::parse_result_t res;
    logic                    out_valid_reg;
    ulcd_pkg::code_t         code_reg;
    logic [6:0]              level_reg;
    logic                    out_free;
    logic                    process;
    logic                    line_full;

    assign line_full     = (held_reg == CW'(LINE_BYTES - 1));
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && (!res.emit || out_free);
    assign s_axis_tready = !in_valid_reg || process;

    ulcd_parser u_parser
    (
        .data_byte  (in_byte_reg),
        .state      (state_reg),
        .line_held  (held_reg != '0),
        .line_full  (line_full),
        .state_next (state_next),
        .result     (res)
    );

    always_comb
    begin
        held_next = held_reg;
        if (res.restart)
            held_next = '0;
        else if (res.count)
            held_next = held_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            state_reg.phase <= ulcd_pkg::PH_START;
            state_reg.value <= '0;
            state_reg.neg   <= 1'b0;
            state_reg.ended <= 1'b0;
        end
        else if (process)
        begin
            held_reg  <= held_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process && res.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process && res.emit)
        begin
            code_reg  <= res.code;
            level_reg <= res.level;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, level_reg};
    assign m_axis_tuser  = code_reg;

    `ULCD_ASSERT_NOW(a_level_only_on_set,
        out_valid_reg && (code_reg != ulcd_pkg::CODE_LEVEL), level_reg == '0,
        "level nonzero on a non-level result")
    `ULCD_ASSERT_NOW(a_empty_line_at_start,
        held_reg == '0, state_reg.phase == ulcd_pkg::PH_START,
        "recognizer left start with no bytes held")
    `ULCD_ASSERT_NOW(a_held_bounded,
        1'b1, held_reg <= CW'(LINE_BYTES - 1),
        "held count beyond line capacity")
    `ULCD_ASSERT_NEXT(a_stalled_byte_kept,
        in_valid_reg && !process, in_valid_reg && $stable(in_byte_reg),
        "stalled byte lost")

endmodule

[src/ulcd_parser.sv]
`timescale 1ns / 1ps

module ulcd_parser
(
    input  logic [7:0]             data_byte,
    input  ulcd_pkg::line_state_t  state,
    input  logic                   line_held,
    input  logic                   line_full,
    output ulcd_pkg::line_state_t  state_next,
    output ulcd_pkg::parse_result_t result
);

    logic                  is_end;
    logic                  is_digit;
    logic                  is_blank;
    logic [3:0]            digit_val;
    logic [10:0]           acc;
    ulcd_pkg::line_state_t adv;

    assign is_end    = (data_byte == ulcd_pkg::CHR_CR) || (data_byte == ulcd_pkg::CHR_LF);
    assign is_digit  = (data_byte >= ulcd_pkg::CHR_ZERO) && (data_byte <= ulcd_pkg::CHR_NINE);
    assign is_blank  = (data_byte == ulcd_pkg::CHR_SPACE) || (data_byte == ulcd_pkg::CHR_TAB)
                    || (data_byte == ulcd_pkg::CHR_VT) || (data_byte == ulcd_pkg::CHR_FF);
    assign digit_val = data_byte[3:0];
    assign acc       = ({4'b0, state.value} << 3) + ({4'b0, state.value} << 1)
                     + {7'b0, digit_val};

    // advance the recognizer by one byte
    always_comb
    begin
        adv = state;
        unique case (state.phase)
            ulcd_pkg::PH_START:
            begin
                if (data_byte == ulcd_pkg::CHR_O)
                    adv.phase = ulcd_pkg::PH_O;
                else if (data_byte == ulcd_pkg::CHR_S)
                    adv.phase = ulcd_pkg::PH_S;
                else if (data_byte == ulcd_pkg::CHR_P)
                    adv.phase = ulcd_pkg::PH_P;
                else
                    adv.phase = ulcd_pkg::PH_FAIL;
            end
            ulcd_pkg::PH_O:
                adv.phase = (data_byte == ulcd_pkg::CHR_F) ? ulcd_pkg::PH_OF : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_OF:
                adv.phase = (data_byte == ulcd_pkg::CHR_F) ? ulcd_pkg::PH_OFF : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_S:
                adv.phase = (data_byte == ulcd_pkg::CHR_T) ? ulcd_pkg::PH_ST : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_ST:
                adv.phase = (data_byte == ulcd_pkg::CHR_A) ? ulcd_pkg::PH_STA : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_STA:
                adv.phase = (data_byte == ulcd_pkg::CHR_T) ? ulcd_pkg::PH_STAT
                                                           : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_STAT:
                adv.phase = (data_byte == ulcd_pkg::CHR_U) ? ulcd_pkg::PH_STATU
                                                           : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_STATU:
                adv.phase = (data_byte == ulcd_pkg::CHR_S) ? ulcd_pkg::PH_STATUS
                                                           : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_P:
                adv.phase = (data_byte == ulcd_pkg::CHR_W) ? ulcd_pkg::PH_PW : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_PW:
                adv.phase = (data_byte == ulcd_pkg::CHR_M) ? ulcd_pkg::PH_PWM : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_PWM:
                adv.phase = (data_byte == ulcd_pkg::CHR_SPACE) ? ulcd_pkg::PH_BLANK
                                                               : ulcd_pkg::PH_FAIL;
            ulcd_pkg::PH_BLANK:
            begin
                if (is_blank)
                    adv.phase = ulcd_pkg::PH_BLANK;
                else if (data_byte == ulcd_pkg::CHR_PLUS)
                    adv.phase = ulcd_pkg::PH_SIGN;
                else if (data_byte == ulcd_pkg::CHR_MINUS)
                begin
                    adv.neg   = 1'b1;
                    adv.phase = ulcd_pkg::PH_SIGN;
                end
                else if (is_digit)
                begin
                    adv.value = {3'b0, digit_val};
                    adv.phase = ulcd_pkg::PH_DIGITS;
                end
                else
                    adv.phase = ulcd_pkg::PH_FAIL;
            end
            ulcd_pkg::PH_SIGN:
            begin
                if (is_digit)
                begin
                    adv.value = {3'b0, digit_val};
                    adv.phase = ulcd_pkg::PH_DIGITS;
                end
                else
                    adv.phase = ulcd_pkg::PH_FAIL;
            end
            ulcd_pkg::PH_DIGITS:
            begin
                if (is_digit)
                    adv.value = (acc > {4'b0, ulcd_pkg::VALUE_CAP}) ? ulcd_pkg::VALUE_CAP
                                                                    : acc[6:0];
                else
                    adv.phase = ulcd_pkg::PH_FAIL;
            end
            default:
                adv.phase = ulcd_pkg::PH_FAIL;
        endcase
    end

    always_comb
    begin
        state_next     = state;
        result.emit    = 1'b0;
        result.restart = 1'b0;
        result.count   = 1'b0;
        result.code    = ulcd_pkg::CODE_CMD;
        result.level   = '0;
        if (is_end)
        begin
            result.emit    = line_held;
            result.restart = 1'b1;
            if (state.phase == ulcd_pkg::PH_OFF)
                result.code = ulcd_pkg::CODE_OFF;
            else if (state.phase == ulcd_pkg::PH_STATUS)
                result.code = ulcd_pkg::CODE_STATUS;
            else if (state.phase == ulcd_pkg::PH_DIGITS)
            begin
                if ((state.value > ulcd_pkg::LEVEL_MAX) || (state.neg && (state.value != '0)))
                    result.code = ulcd_pkg::CODE_RANGE;
                else
                begin
                    result.code  = ulcd_pkg::CODE_LEVEL;
                    result.level = state.value;
                end
            end
        end
        else if (!line_full)
        begin
            result.count = 1'b1;
            if (!state.ended)
            begin
                if (data_byte == ulcd_pkg::CHR_NUL)
                    state_next.ended = 1'b1;
                else
                    state_next = adv;
            end
        end
        else
        begin
            result.emit    = 1'b1;
            result.restart = 1'b1;
            result.code    = ulcd_pkg::CODE_LONG;
        end
        if (result.restart)
        begin
            state_next.phase = ulcd_pkg::PH_START;
            state_next.value = '0;
            state_next.neg   = 1'b0;
            state_next.ended = 1'b0;
        end
    end

endmodule

[bench/ulcd_checker.sv]
`timescale 1ns / 1ps

module ulcd_checker
    import ulcd_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [6:0] level, [7] zero
    input  logic [2:0] m_axis_tuser,   // [2:0] response_code
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        code_t      code;
        logic [6:0] level;
    } reply_t;

    reply_t      replies_due[$];
    int unsigned held;
    phase_t      phase;
    logic [6:0]  number;
    logic        negative;
    logic        ended;

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_line();
        held = 0;
        phase = PH_START;
        number = '0;
        negative = 1'b0;
        ended = 1'b0;
    endtask

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHR_ZERO) && (b <= CHR_NINE);
    endfunction

    function automatic phase_t after_match(input logic [7:0] b, input logic [7:0] want_chr,
                                           input phase_t hit);
        return (b == want_chr) ? hit : PH_FAIL;
    endfunction

    task automatic recognize(input logic [7:0] b);
        int v;
        v = 0;
        case (phase)
            PH_START:
            begin
                if (b == CHR_O)
                    phase = PH_O;
                else if (b == CHR_S)
                    phase = PH_S;
                else if (b == CHR_P)
                    phase = PH_P;
                else
                    phase = PH_FAIL;
            end
            PH_O:     phase = after_match(b, CHR_F, PH_OF);
            PH_OF:    phase = after_match(b, CHR_F, PH_OFF);
            PH_S:     phase = after_match(b, CHR_T, PH_ST);
            PH_ST:    phase = after_match(b, CHR_A, PH_STA);
            PH_STA:   phase = after_match(b, CHR_T, PH_STAT);
            PH_STAT:  phase = after_match(b, CHR_U, PH_STATU);
            PH_STATU: phase = after_match(b, CHR_S, PH_STATUS);
            PH_P:     phase = after_match(b, CHR_W, PH_PW);
            PH_PW:    phase = after_match(b, CHR_M, PH_PWM);
            PH_PWM:   phase = after_match(b, CHR_SPACE, PH_BLANK);
            PH_BLANK:
            begin
                if (b == CHR_SPACE || b == CHR_TAB || b == CHR_VT || b == CHR_FF)
                    phase = PH_BLANK;
                else if (b == CHR_PLUS)
                    phase = PH_SIGN;
                else if (b == CHR_MINUS)
                begin
                    negative = 1'b1;
                    phase = PH_SIGN;
                end
                else if (is_digit(b))
                begin
                    number = 7'(b - CHR_ZERO);
                    phase = PH_DIGITS;
                end
                else
                    phase = PH_FAIL;
            end
            PH_SIGN:
            begin
                if (is_digit(b))
                begin
                    number = 7'(b - CHR_ZERO);
                    phase = PH_DIGITS;
                end
                else
                    phase = PH_FAIL;
            end
            PH_DIGITS:
            begin
                if (is_digit(b))
                begin
                    v = int'(number) * 10 + int'(b - CHR_ZERO);
                    number = (v > int'(VALUE_CAP)) ? VALUE_CAP : 7'(v);
                end
                else
                    phase = PH_FAIL;
            end
            default:  phase = PH_FAIL;
        endcase
    endtask

    function automatic reply_t line_reply();
        reply_t r;
        r.code = CODE_CMD;
        r.level = '0;
        if (phase == PH_OFF)
            r.code = CODE_OFF;
        else if (phase == PH_STATUS)
            r.code = CODE_STATUS;
        else if (phase == PH_DIGITS)
        begin
            if (number > LEVEL_MAX || (negative && number != 0))
                r.code = CODE_RANGE;
            else
            begin
                r.code = CODE_LEVEL;
                r.level = number;
            end
        end
        return r;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        reply_t r;
        if (b == CHR_CR || b == CHR_LF)
        begin
            if (held != 0)
            begin
                r = line_reply();
                replies_due.push_back(r);
                clear_line();
            end
        end
        else if (held < LINE_BYTES - 1)
        begin
            held++;
            if (!ended)
            begin
                if (b == CHR_NUL)
                    ended = 1'b1;
                else
                    recognize(b);
            end
        end
        else
        begin
            clear_line();
            r.code = CODE_LONG;
            r.level = '0;
            replies_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            replies_due.delete();
            clear_line();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                    report($sformatf("unexpected transfer code %0d level %0d",
                                     m_axis_tuser, m_axis_tdata[6:0]));
                else
                begin
                    want = replies_due.pop_front();
                    if (m_axis_tuser !== 3'(want.code))
                        report($sformatf("code %0d, want %0d", m_axis_tuser, want.code));
                    if (m_axis_tdata[6:0] !== want.level)
                        report($sformatf("level %0d, want %0d", m_axis_tdata[6:0], want.level));
                    if (m_axis_tdata[7] !== 1'b0)
                        report("tdata pad bit set");
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata);
        end
        pending = replies_due.size();
    end

endmodule

[bench/uart_line_command_decoder_tb.sv]
`timescale 1ns / 1ps

module uart_line_command_decoder_tb;
    import ulcd_pkg::*;

    localparam int ITEMS = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;     // [7:0] data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [6:0] level, [7] zero
    logic [2:0] m_axis_tuser;          // [2:0] response_code

    int         fail_count;
    int         pending;
    int         idle_mode = 0;
    int         cycles = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         sent = 0;
    logic [7:0] line_bytes[$];

    uart_line_command_decoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ulcd_checker reply_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold off once for a long stretch so the block fills and stalls its input
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (idle_mode == 2 && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (idle_mode == 0)
            m_axis_tready <= ($urandom_range(99) >= 76);
        else if (idle_mode == 1)
            m_axis_tready <= ($urandom_range(99) >= 29);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic push_byte(input logic [7:0] b);
        while ((idle_mode == 0 && $urandom_range(99) < 29) ||
               (idle_mode == 1 && $urandom_range(99) < 76))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHR_CR || b == CHR_LF);
        return b;
    endfunction

    task automatic mangle_line();
        int k;
        k = $urandom_range(line_bytes.size() - 1);
        case ($urandom_range(2))
            0:
            begin
                if (k == 0)
                    line_bytes.delete();
                else
                    line_bytes = line_bytes[0:k-1];
            end
            1:       line_bytes[k] = plain_byte();
            default: line_bytes.push_back(plain_byte());
        endcase
    endtask

    task automatic append_level();
        int    v;
        string digits;
        logic [7:0] blanks[4];
        blanks = '{CHR_SPACE, CHR_TAB, CHR_VT, CHR_FF};
        append_text("PWM ");
        repeat ($urandom_range(3))
            line_bytes.push_back(blanks[$urandom_range(3)]);
        case ($urandom_range(2))
            0:       line_bytes.push_back(CHR_PLUS);
            1:       line_bytes.push_back(CHR_MINUS);
            default: ;
        endcase
        case ($urandom_range(4))
            0:       v = $urandom_range(100);
            1:       v = 95 + $urandom_range(10);
            2:       v = $urandom_range(99999);
            3:       v = $urandom_range(9);
            default: v = $urandom_range(120);
        endcase
        digits = $sformatf("%0d", v);
        if ($urandom_range(9) == 0)
            digits = {"00", digits};
        if ($urandom_range(9) != 0)
            append_text(digits);
        if ($urandom_range(9) == 0)
            line_bytes.push_back(plain_byte());
    endtask

    task automatic build_line();
        int pick;
        pick = $urandom_range(99);
        line_bytes.delete();
        if (pick < 12)
            append_text("OFF");
        else if (pick < 24)
            append_text("STATUS");
        else if (pick < 60)
            append_level();
        else if (pick < 68)
        begin
            if ($urandom_range(1) == 0)
                line_bytes.push_back(CHR_NUL);
            else
            begin
                case ($urandom_range(2))
                    0:       append_text("OFF");
                    1:       append_text("STATUS");
                    default: append_text("PWM 42");
                endcase
                line_bytes.push_back(CHR_NUL);
            end
            repeat ($urandom_range(4))
                line_bytes.push_back(plain_byte());
        end
        else if (pick < 78)
            repeat ($urandom_range(28, 40))
                line_bytes.push_back(plain_byte());
        else
            repeat ($urandom_range(1, 8))
                line_bytes.push_back(8'($urandom_range(255)));
        if (pick < 60 && line_bytes.size() != 0 && $urandom_range(4) == 0)
            mangle_line();
        line_bytes.push_back(($urandom_range(1) == 0) ? CHR_CR : CHR_LF);
        if ($urandom_range(6) == 0)
            line_bytes.push_back(($urandom_range(1) == 0) ? CHR_CR : CHR_LF);
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            push_byte(line_bytes[i]);
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        line_bytes.delete();
        append_text("OFF");
        line_bytes.push_back(CHR_CR);
        append_text("STATUS");
        line_bytes.push_back(CHR_LF);
        line_bytes.push_back(CHR_CR);
        append_text("PWM -0");
        line_bytes.push_back(CHR_CR);
        line_bytes.push_back(CHR_NUL);
        line_bytes.push_back(CHR_LF);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(CHR_CR);
        send_line();

        while (sent < ITEMS)
        begin
            if (sent >= 2 * ITEMS / 3)
                idle_mode = 2;
            else if (sent >= ITEMS / 3)
                idle_mode = 1;
            build_line();
            send_line();
        end
        s_axis_tvalid <= 1'b0;

        repeat (2)
            @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
